>>> hdl/jsue_pkg.sv
`default_nettype none

package jsue_pkg;

    localparam int MAX_RESULTS = 6;
    localparam int RES_CNT_W   = 3;

    localparam logic [7:0]  CTRL_MAX = 8'd31;
    localparam logic [7:0]  DEL_CHAR = 8'd127;
    localparam logic [15:0] CP_LSEP  = 16'h2028;
    localparam logic [15:0] CP_PSEP  = 16'h2029;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       bad_utf8;
    } out_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [RES_CNT_W-1:0]        cnt;
        logic                        bad;
    } grp_t;

endpackage

`default_nettype wire

>>> hdl/jsue_decoder.sv
`default_nettype none

module jsue_decoder (
    input  logic           clk,
    input  logic           rst_n,
    input  jsue_pkg::in_t  item,
    input  logic           take,
    output jsue_pkg::grp_t grp
);
    import jsue_pkg::*;

    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_DQUOTE = "\"";
    localparam logic [7:0] CH_SQUOTE = "'";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_X      = "x";
    localparam logic [7:0] CH_U      = "u";
    localparam logic [7:0] CH_2      = "2";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_8      = "8";
    localparam logic [7:0] CH_9      = "9";

    function automatic logic [7:0] esc_code(input logic [7:0] c);
        logic [7:0] e;
        unique case (c)
            8'd8:      e = "b";
            8'd9:      e = "t";
            8'd10:     e = "n";
            8'd11:     e = "v";
            8'd12:     e = "f";
            8'd13:     e = "r";
            CH_DQUOTE: e = CH_DQUOTE;
            CH_SQUOTE: e = CH_SQUOTE;
            CH_BSLASH: e = CH_BSLASH;
            default:   e = 8'h00;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        if (n < 4'd10)
        begin
            d = 8'h30 + {4'h0, n};
        end
        else
        begin
            d = 8'h57 + {4'h0, n};
        end
        return d;
    endfunction

    logic [2:0][7:0] held_reg;
    logic [2:0][7:0] held_next;
    logic [1:0]      hc_reg;
    logic [1:0]      hc_next;
    logic [1:0]      exp_reg;
    logic [1:0]      exp_next;
    logic            disc_reg;
    logic            disc_next;

    logic [7:0]  b;
    logic        eot;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        cont_ok;
    logic [1:0]  exp_m;
    logic [1:0]  need;
    logic [15:0] cp;
    logic [7:0]  esc_ch;
    logic        fail;

    always_comb
    begin
        b         = item.in_byte;
        eot       = item.end_of_text;
        held_next = held_reg;
        hc_next   = hc_reg;
        exp_next  = exp_reg;
        disc_next = disc_reg;
        grp       = '0;
        fail      = 1'b0;

        lo = 8'h80;
        hi = 8'hBF;
        if (held_reg[0] == 8'hE0)
        begin
            lo = 8'hA0;
        end
        if (held_reg[0] == 8'hED)
        begin
            hi = 8'h9F;
        end
        if (held_reg[0] == 8'hF0)
        begin
            lo = 8'h90;
        end
        if (held_reg[0] == 8'hF4)
        begin
            hi = 8'h8F;
        end
        if (hc_reg == 2'd1)
        begin
            cont_ok = (b >= lo) && (b <= hi);
        end
        else
        begin
            cont_ok = (b >= 8'h80) && (b <= 8'hBF);
        end

        exp_m  = exp_reg - 2'd1;
        cp     = {held_reg[0][3:0], held_reg[1][5:0], b[5:0]};
        esc_ch = esc_code(b);

        if (b >= 8'hC2 && b <= 8'hDF)
        begin
            need = 2'd1;
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            need = 2'd2;
        end
        else if (b >= 8'hF0 && b <= 8'hF4)
        begin
            need = 2'd3;
        end
        else
        begin
            need = 2'd0;
        end

        if (disc_reg)
        begin
            if (eot)
            begin
                disc_next = 1'b0;
            end
        end
        else if (exp_reg == 2'd0)
        begin
            if (!b[7])
            begin
                if (esc_ch != 8'h00)
                begin
                    grp.bytes[0] = CH_BSLASH;
                    grp.bytes[1] = esc_ch;
                    grp.cnt      = 3'd2;
                end
                else if (b <= CTRL_MAX || b == CH_LT || b == DEL_CHAR)
                begin
                    grp.bytes[0] = CH_BSLASH;
                    grp.bytes[1] = CH_X;
                    grp.bytes[2] = hex_digit(b[7:4]);
                    grp.bytes[3] = hex_digit(b[3:0]);
                    grp.cnt      = 3'd4;
                end
                else
                begin
                    grp.bytes[0] = b;
                    grp.cnt      = 3'd1;
                end
            end
            else if (need == 2'd0 || eot)
            begin
                fail = 1'b1;
            end
            else
            begin
                held_next[0] = b;
                hc_next      = 2'd1;
                exp_next     = need;
            end
        end
        else if (!cont_ok)
        begin
            fail = 1'b1;
        end
        else if (exp_m != 2'd0)
        begin
            if (eot || hc_reg == 2'd3)
            begin
                fail = 1'b1;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (hc_reg == 2'(i))
                    begin
                        held_next[i] = b;
                    end
                end
                hc_next  = hc_reg + 2'd1;
                exp_next = exp_m;
            end
        end
        else
        begin
            exp_next = 2'd0;
            hc_next  = 2'd0;
            if (hc_reg == 2'd2 && (cp == CP_LSEP || cp == CP_PSEP))
            begin
                grp.bytes[0] = CH_BSLASH;
                grp.bytes[1] = CH_U;
                grp.bytes[2] = CH_2;
                grp.bytes[3] = CH_0;
                grp.bytes[4] = CH_2;
                grp.bytes[5] = (cp == CP_LSEP) ? CH_8 : CH_9;
                grp.cnt      = 3'd6;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (2'(i) < hc_reg)
                    begin
                        grp.bytes[i] = held_reg[i];
                    end
                end
                for (int i = 0; i < 4; i++)
                begin
                    if (hc_reg == 2'(i))
                    begin
                        grp.bytes[i] = b;
                    end
                end
                grp.cnt = {1'b0, hc_reg} + 3'd1;
            end
        end

        if (fail)
        begin
            hc_next   = 2'd0;
            exp_next  = 2'd0;
            disc_next = !eot;
            grp       = '0;
            grp.cnt   = 3'd1;
            grp.bad   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg   <= 2'd0;
            exp_reg  <= 2'd0;
            disc_reg <= 1'b0;
        end
        else if (take)
        begin
            hc_reg   <= hc_next;
            exp_reg  <= exp_next;
            disc_reg <= disc_next;
        end
    end

`ifndef SYNTHESIS
    a_disc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> (hc_reg == 2'd0 && exp_reg == 2'd0))
        else $error("discard mode with a character pending");

    a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg != 2'd0) |-> (hc_reg != 2'd0 && hc_reg + exp_reg <= 3'd4))
        else $error("pending character count out of range");
`endif

endmodule

`default_nettype wire

>>> hdl/jsue_serializer.sv
`default_nettype none

module jsue_serializer (
    input  logic           clk,
    input  logic           rst_n,
    input  jsue_pkg::grp_t grp,
    input  logic           load,
    output logic           ready,
    output logic           valid,
    input  logic           stall,
    output jsue_pkg::out_t res
);
    import jsue_pkg::*;

    logic [MAX_RESULTS-1:0][7:0] bytes_reg;
    logic [RES_CNT_W-1:0]        cnt_reg;
    logic                        bad_reg;
    logic                        vld_reg;
    logic [RES_CNT_W-1:0]        idx_reg;
    logic                        last;

    assign last  = (idx_reg == cnt_reg - 3'd1);
    assign ready = !vld_reg || (!stall && last);
    assign valid = vld_reg;

    always_comb
    begin
        res          = '0;
        res.out_byte = bytes_reg[idx_reg];
        res.run_last = last;
        res.bad_utf8 = bad_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= grp.bytes;
            cnt_reg   <= grp.cnt;
            bad_reg   <= grp.bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            vld_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (vld_reg && !stall)
        begin
            if (last)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> (idx_reg < cnt_reg && cnt_reg <= 3'd6))
        else $error("result index beyond group size");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && bad_reg) |-> (cnt_reg == 3'd1 && res.out_byte == 8'h00))
        else $error("error request is not a single zero byte");
`endif

endmodule

`default_nettype wire

>>> hdl/js_string_utf8_escaper_unit.sv
`default_nettype none

// Escapes UTF-8 text for use inside a JavaScript string literal.
// The text channel carries one source byte per request, with end_of_text on
// the final byte. The esc channel carries one escaped byte per request, with
// run_last on the last byte produced for a source byte and bad_utf8 on the
// single error request that aborts invalid or truncated text.
// A source byte is registered at the edge it is accepted and decoded in the
// next cycle; its results are then loaded into the output buffer and are
// offered on esc from there.
// Plain text, whose source bytes yield at most one result each, runs at one
// byte per cycle while esc does not stall. A byte with n results occupies
// the output buffer until all are taken; later bytes with results stall.
// Bytes that only continue a pending character, and bytes dropped after an
// error, yield nothing and pass without touching the output side.
// When esc is stalled the current result holds; a source byte with results
// waits in the input register and the text channel then stalls.
// Reset clears all pending requests and the decoder state; the block is
// ready for new text as soon as reset is released.
module js_string_utf8_escaper_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           text_valid,
    output logic           text_stall,
    input  jsue_pkg::in_t  text,
    output logic           esc_valid,
    input  logic           esc_stall,
    output jsue_pkg::out_t esc
);
    import jsue_pkg::*;

    in_t  s1_reg;
    logic s1_vld_reg;
    grp_t grp;
    logic ser_ready;
    logic move;
    logic load;

    assign move       = s1_vld_reg && (grp.cnt == 3'd0 || ser_ready);
    assign load       = s1_vld_reg && grp.cnt != 3'd0 && ser_ready;
    assign text_stall = s1_vld_reg && !move;

    always_ff @(posedge clk)
    begin
        if (text_valid && !text_stall)
        begin
            s1_reg <= text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (!text_stall)
        begin
            s1_vld_reg <= text_valid;
        end
    end

    jsue_decoder u_decoder (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (s1_reg),
        .take  (move),
        .grp   (grp)
    );

    jsue_serializer u_serializer (
        .clk   (clk),
        .rst_n (rst_n),
        .grp   (grp),
        .load  (load),
        .ready (ser_ready),
        .valid (esc_valid),
        .stall (esc_stall),
        .res   (esc)
    );

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> esc_valid)
        else $error("loaded group not offered on the output");
`endif

endmodule

`default_nettype wire
